/* sv/jsu_pkg.sv */
`timescale 1ns / 1ps

package jsu_pkg;

  // Depth of the command queue between the decoder and the byte expander.
  localparam int unsigned JSU_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_ERROR  = 2'd2
  } jsu_kind_e;

  // One decoded input byte: an optional code point, an optional second code
  // unit (an unpaired unit that followed a held high surrogate), and an
  // optional trailing single result. They are emitted in that order.
  typedef struct packed {
    logic        a_vld;
    logic [20:0] a_cp;
    logic        b_vld;
    logic [15:0] b_cp;
    logic        t_vld;
    logic [7:0]  t_byte;
    jsu_kind_e   t_kind;
  } jsu_cmd_t;

  // Number of UTF-8 bytes for a code point.
  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp < 21'h00080) begin
      len = 3'd1;
    end else if (cp < 21'h00800) begin
      len = 3'd2;
    end else if (cp < 21'h10000) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Byte number idx of the UTF-8 form of a code point.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (utf8_len(cp))
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        unique case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0: b = {5'b11110, cp[20:18]};
          2'd1: b = {2'b10, cp[17:12]};
          2'd2: b = {2'b10, cp[11:6]};
          2'd3: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

/* sv/jsu_front.sv */
`timescale 1ns / 1ps

module jsu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_eot_i,
  input  logic             queue_full_i,
  output logic             in_ready_o,
  output logic             push_o,
  output jsu_pkg::jsu_cmd_t cmd_o
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_ESC,
    PH_HEX,
    PH_PEND,
    PH_PEND_ESC,
    PH_PEND_HEX
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] pend_q, pend_d;

  logic        accept;
  logic [3:0]  hex_val;
  logic        hex_ok;
  logic [15:0] acc_next;
  logic        last_digit;
  logic        esc_ok;
  logic [7:0]  esc_byte;
  logic        err;
  logic        nxt_high;
  logic        nxt_low;
  jsu_cmd_t    cmd;

  assign accept     = in_valid_i && !queue_full_i;
  assign in_ready_o = !queue_full_i;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'h0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = in_byte_i[3:0];
    end else if ((in_byte_i >= 8'h61 && in_byte_i <= 8'h66) ||
                 (in_byte_i >= 8'h41 && in_byte_i <= 8'h46)) begin
      hex_val = in_byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = in_byte_i;
    unique case (in_byte_i)
      8'h22, 8'h5C, 8'h2F: esc_byte = in_byte_i;
      8'h62:   esc_byte = 8'h08;
      8'h66:   esc_byte = 8'h0C;
      8'h6E:   esc_byte = 8'h0A;
      8'h72:   esc_byte = 8'h0D;
      8'h74:   esc_byte = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  assign acc_next   = {acc_q[11:0], hex_val};
  assign last_digit = (cnt_q == 2'd3);
  assign nxt_high   = (acc_next >= 16'hD800) && (acc_next <= 16'hDBFF);
  assign nxt_low    = (acc_next >= 16'hDC00) && (acc_next <= 16'hDFFF);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    pend_d  = pend_q;
    err     = 1'b0;
    cmd     = '0;
    cmd.t_kind = KIND_DATA;

    unique case (phase_q)
      PH_IDLE: begin
        if (in_byte_i == 8'h22) begin
          phase_d = PH_BODY;
        end else begin
          err = 1'b1;
        end
      end
      PH_BODY, PH_PEND: begin
        if (phase_q == PH_PEND && in_byte_i == 8'h5C) begin
          phase_d = PH_PEND_ESC;
        end else begin
          if (phase_q == PH_PEND) begin
            cmd.a_vld = 1'b1;
            cmd.a_cp  = {5'd0, pend_q};
            pend_d    = '0;
          end
          phase_d = PH_BODY;
          if (in_byte_i == 8'h22) begin
            cmd.t_vld  = 1'b1;
            cmd.t_kind = KIND_CLOSED;
            phase_d    = PH_IDLE;
            cnt_d      = '0;
            acc_d      = '0;
            pend_d     = '0;
          end else if (in_byte_i == 8'h5C) begin
            phase_d = PH_ESC;
          end else begin
            cmd.t_vld  = 1'b1;
            cmd.t_byte = in_byte_i;
          end
        end
      end
      PH_ESC, PH_PEND_ESC: begin
        if (in_byte_i == 8'h75) begin
          phase_d = (phase_q == PH_ESC) ? PH_HEX : PH_PEND_HEX;
          cnt_d   = '0;
          acc_d   = '0;
        end else if (esc_ok) begin
          if (phase_q == PH_PEND_ESC) begin
            cmd.a_vld = 1'b1;
            cmd.a_cp  = {5'd0, pend_q};
            pend_d    = '0;
          end
          cmd.t_vld  = 1'b1;
          cmd.t_byte = esc_byte;
          phase_d    = PH_BODY;
        end else begin
          err = 1'b1;
        end
      end
      PH_HEX, PH_PEND_HEX: begin
        if (!hex_ok) begin
          err = 1'b1;
        end else begin
          acc_d = acc_next;
          cnt_d = cnt_q + 2'd1;
          if (last_digit) begin
            cnt_d   = '0;
            phase_d = PH_BODY;
            if (phase_q == PH_PEND_HEX) begin
              pend_d    = '0;
              cmd.a_vld = 1'b1;
              if (nxt_low) begin
                // Surrogate pair: 0x10000 + (hi - 0xD800) * 1024 + (lo - 0xDC00).
                cmd.a_cp = 21'h10000 + {1'b0, pend_q[9:0], acc_next[9:0]};
              end else begin
                cmd.a_cp = {5'd0, pend_q};
                if (nxt_high) begin
                  pend_d  = acc_next;
                  phase_d = PH_PEND;
                end else begin
                  cmd.b_vld = 1'b1;
                  cmd.b_cp  = acc_next;
                end
              end
            end else if (nxt_high) begin
              pend_d  = acc_next;
              phase_d = PH_PEND;
            end else begin
              cmd.a_vld = 1'b1;
              cmd.a_cp  = {5'd0, acc_next};
            end
          end
        end
      end
      default: err = 1'b1;
    endcase

    // The text ending inside the string turns the step into a single error.
    if (in_eot_i && !(cmd.t_vld && cmd.t_kind != KIND_DATA)) begin
      err = 1'b1;
    end
    if (err) begin
      cmd        = '0;
      cmd.t_vld  = 1'b1;
      cmd.t_kind = KIND_ERROR;
    end
    if (err || in_eot_i) begin
      phase_d = PH_IDLE;
      cnt_d   = '0;
      acc_d   = '0;
      pend_d  = '0;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.a_vld || cmd.b_vld || cmd.t_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      pend_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      pend_q  <= pend_d;
    end
  end

  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_eot_i |=> phase_q == PH_IDLE && pend_q == 16'd0)
    else $error("state not cleared after end of text");

  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && cmd.t_kind == KIND_ERROR |-> !cmd.a_vld && !cmd.b_vld)
    else $error("error result mixed with data");

  a_pend_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PEND |-> pend_q >= 16'hD800 && pend_q <= 16'hDBFF)
    else $error("held unit is not a high surrogate");

endmodule

/* sv/jsu_queue.sv */
`timescale 1ns / 1ps

module jsu_queue #(
  parameter int unsigned Depth = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jsu_pkg::jsu_cmd_t wdata_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output jsu_pkg::jsu_cmd_t rdata_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jsu_cmd_t          mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

/* sv/jsu_back.sv */
`timescale 1ns / 1ps

module jsu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  jsu_pkg::jsu_cmd_t cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic [1:0]        out_kind_o,
  output logic              out_last_o
);
  import jsu_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  jsu_kind_e  kind_q, kind_d;
  logic       last_q, last_d;

  logic [2:0] na, nb, nab, total;
  logic [2:0] boff;
  logic       load;
  logic       elem_last;

  assign na    = cmd_i.a_vld ? utf8_len(cmd_i.a_cp) : 3'd0;
  assign nb    = cmd_i.b_vld ? utf8_len({5'd0, cmd_i.b_cp}) : 3'd0;
  assign nab   = na + nb;
  assign total = nab + {2'd0, cmd_i.t_vld};
  assign boff  = idx_q - na;

  assign load      = cmd_valid_i && (!vld_q || out_ready_i);
  assign elem_last = (idx_q == total - 3'd1);
  assign pop_o     = load && elem_last;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q && !out_ready_i;
    byte_d = byte_q;
    kind_d = kind_q;
    last_d = last_q;
    if (load) begin
      vld_d  = 1'b1;
      last_d = elem_last;
      idx_d  = elem_last ? 3'd0 : idx_q + 3'd1;
      if (idx_q < na) begin
        byte_d = utf8_byte(cmd_i.a_cp, idx_q[1:0]);
        kind_d = KIND_DATA;
      end else if (idx_q < nab) begin
        byte_d = utf8_byte({5'd0, cmd_i.b_cp}, boff[1:0]);
        kind_d = KIND_DATA;
      end else begin
        byte_d = (cmd_i.t_kind == KIND_DATA) ? cmd_i.t_byte : 8'h00;
        kind_d = cmd_i.t_kind;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    kind_q <= kind_d;
    last_q <= last_d;
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;
  assign out_kind_o  = kind_q;
  assign out_last_o  = last_q;

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && kind_q != KIND_DATA |-> last_q)
    else $error("status result is not the last of its run");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> idx_q < total)
    else $error("expander index past end of command");

  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_valid_i |-> idx_q == 3'd0)
    else $error("expander index left over without a command");

endmodule

/* sv/json_string_unescape_utf8.sv */
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata = in_byte, tlast = end_of_text
// m_axis    out  m_axis_tvalid/tready      tdata = out_byte, tuser = kind,
//                                          tlast = run_last
//
// The decoder takes one input byte per cycle while the command queue has room.
// The expander gives one result per cycle while the receiver is ready, so a byte
// that decodes into several results (up to six) holds the output for each of
// them in turn; the queue of JSU_QUEUE_DEPTH entries absorbs these bursts. A
// byte's results pass through the queue and then the expander's output register
// before they are presented. Reset is asynchronous and active low and leaves the
// block awaiting an opening quote. A stalled output holds its transfer and backs
// up into the queue; the input stalls only when the queue is full.
`timescale 1ns / 1ps

module json_string_unescape_utf8 #(
  parameter int unsigned QueueDepth = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_text
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast    // run_last
);
  import jsu_pkg::*;

  logic     push;
  logic     pop;
  logic     full;
  logic     head_valid;
  jsu_cmd_t push_cmd;
  jsu_cmd_t head_cmd;

  // Front: runs the escape state machine and turns each byte that yields results into a command.
  jsu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .in_eot_i     (s_axis_tlast),
    .queue_full_i (full),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Commands wait here so that the decoder and the expander stall on their own.
  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .rdata_o (head_cmd)
  );

  // Back: spells each command out as UTF-8 bytes, copied bytes and status results.
  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

/* bench/jsu_stream_checker.sv */
`timescale 1ns / 1ps

module jsu_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned closed_o,
  output int unsigned flagged_o
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [2:0] {
    DEC_IDLE,
    DEC_BODY,
    DEC_ESC,
    DEC_HEX,
    DEC_HELD,
    DEC_HELD_ESC,
    DEC_HELD_HEX
  } dec_phase_e;

  typedef struct packed {
    logic [7:0] data;
    jsu_kind_e  kind;
    logic       last;
  } utf8_result_t;

  dec_phase_e   phase_q;
  logic [2:0]   digits_q;
  logic [15:0]  unit_q;
  logic [15:0]  held_q;
  utf8_result_t step_q[$];
  utf8_result_t utf8_expected_q[$];

  function automatic void push_result(logic [7:0] b, jsu_kind_e k);
    utf8_result_t r;
    r.data = b;
    r.kind = k;
    r.last = 1'b0;
    step_q = {step_q, r};
  endfunction

  function automatic void push_code(logic [20:0] cp);
    if (cp < 21'h00080) begin
      push_result(cp[7:0], KIND_DATA);
    end else if (cp < 21'h00800) begin
      push_result(8'hC0 | 8'(cp >> 6), KIND_DATA);
      push_result(8'h80 | 8'(cp & 21'h3F), KIND_DATA);
    end else if (cp < 21'h10000) begin
      push_result(8'hE0 | 8'(cp >> 12), KIND_DATA);
      push_result(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA);
      push_result(8'h80 | 8'(cp & 21'h3F), KIND_DATA);
    end else begin
      push_result(8'hF0 | 8'((cp >> 18) & 21'h07), KIND_DATA);
      push_result(8'h80 | 8'((cp >> 12) & 21'h3F), KIND_DATA);
      push_result(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA);
      push_result(8'h80 | 8'(cp & 21'h3F), KIND_DATA);
    end
  endfunction

  function automatic void clear_decoder();
    phase_q  = DEC_IDLE;
    digits_q = 3'd0;
    unit_q   = 16'h0000;
    held_q   = 16'h0000;
  endfunction

  // An error replaces everything the byte produced so far.
  function automatic void flag_error();
    step_q.delete();
    push_result(8'h00, KIND_ERROR);
    clear_decoder();
  endfunction

  function automatic int nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function automatic void string_byte(logic [7:0] c);
    if (c == CH_QUOTE) begin
      push_result(8'h00, KIND_CLOSED);
      clear_decoder();
    end else if (c == CH_BSLASH) begin
      phase_q = DEC_ESC;
    end else begin
      push_result(c, KIND_DATA);
    end
  endfunction

  function automatic void escape_char(logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    case (c)
      8'h22:   v = 8'h22;  // quote
      8'h5C:   v = 8'h5C;  // backslash
      8'h2F:   v = 8'h2F;  // slash
      8'h62:   v = 8'h08;  // b
      8'h66:   v = 8'h0C;  // f
      8'h6E:   v = 8'h0A;  // n
      8'h72:   v = 8'h0D;  // r
      8'h74:   v = 8'h09;  // t
      CH_U: begin
        phase_q  = DEC_HEX;
        digits_q = 3'd0;
        unit_q   = 16'h0000;
        return;
      end
      default: begin
        flag_error();
        return;
      end
    endcase
    push_result(v, KIND_DATA);
    phase_q = DEC_BODY;
  endfunction

  // Returns 1 when this digit completes the four-digit code unit.
  function automatic logic hex_step(logic [7:0] c, output logic bad);
    int d;
    d   = nibble_of(c);
    bad = 1'b0;
    if (d < 0) begin
      bad = 1'b1;
      return 1'b0;
    end
    unit_q   = {unit_q[11:0], 4'(d)};
    digits_q = digits_q + 3'd1;
    return digits_q >= 3'd4;
  endfunction

  function automatic void take_unit(logic [15:0] v);
    if (v >= 16'hD800 && v <= 16'hDBFF) begin
      held_q  = v;
      phase_q = DEC_HELD;
    end else begin
      push_code(21'(v));
      phase_q = DEC_BODY;
    end
  endfunction

  // Works out every result caused by one accepted input byte and queues them.
  function automatic void decode_byte(logic [7:0] c, logic eot);
    logic        bad;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [20:0] cp;
    step_q.delete();
    case (phase_q)
      DEC_IDLE: begin
        if (c == CH_QUOTE) phase_q = DEC_BODY;
        else flag_error();
      end
      DEC_BODY: string_byte(c);
      DEC_ESC:  escape_char(c);
      DEC_HEX: begin
        if (hex_step(c, bad)) begin
          digits_q = 3'd0;
          take_unit(unit_q);
        end else if (bad) begin
          flag_error();
        end
      end
      DEC_HELD: begin
        if (c == CH_BSLASH) begin
          phase_q = DEC_HELD_ESC;
        end else begin
          // The held surrogate goes out alone, then the byte is handled as string content.
          push_code(21'(held_q));
          held_q  = 16'h0000;
          phase_q = DEC_BODY;
          string_byte(c);
        end
      end
      DEC_HELD_ESC: begin
        if (c == CH_U) begin
          phase_q  = DEC_HELD_HEX;
          digits_q = 3'd0;
          unit_q   = 16'h0000;
        end else begin
          push_code(21'(held_q));
          held_q = 16'h0000;
          escape_char(c);
        end
      end
      DEC_HELD_HEX: begin
        if (hex_step(c, bad)) begin
          lo       = unit_q;
          hi       = held_q;
          digits_q = 3'd0;
          held_q   = 16'h0000;
          if (lo >= 16'hDC00 && lo <= 16'hDFFF) begin
            cp = 21'h10000 + ((21'(hi) - 21'hD800) << 10) + (21'(lo) - 21'hDC00);
            push_code(cp);
            phase_q = DEC_BODY;
          end else begin
            // Not a pair: the high half goes out, the second unit stands alone.
            push_code(21'(hi));
            take_unit(lo);
          end
        end else if (bad) begin
          flag_error();
        end
      end
      default: flag_error();
    endcase

    // End of text always leaves the decoder idle; unless the string closed or
    // an error was already given, the byte yields a single error.
    if (eot) begin
      if (!(step_q.size() > 0 && step_q[$].kind != KIND_DATA)) flag_error();
      clear_decoder();
    end

    foreach (step_q[i]) begin
      if (i == step_q.size() - 1) step_q[i].last = 1'b1;
      utf8_expected_q = {utf8_expected_q, step_q[i]};
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    utf8_result_t want;
    if (!rst_ni) begin
      clear_decoder();
      utf8_expected_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
      checked_o  = 0;
      closed_o   = 0;
      flagged_o  = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        checked_o++;
        if (m_axis_tuser == KIND_CLOSED) closed_o++;
        if (m_axis_tuser == KIND_ERROR) flagged_o++;
        if (utf8_expected_q.size() == 0) begin
          if (fail_cnt_o < 10)
            $display("%0t: unexpected result data %02h kind %0d last %0b", $time,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fail_cnt_o++;
        end else begin
          want = utf8_expected_q.pop_front();
          if (m_axis_tdata !== want.data || m_axis_tuser !== want.kind ||
              m_axis_tlast !== want.last) begin
            if (fail_cnt_o < 10)
              $display("%0t: result %0d expected data %02h kind %0d last %0b, got %02h %0d %0b",
                       $time, checked_o, want.data, want.kind, want.last,
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
            fail_cnt_o++;
          end
        end
      end
      pending_o = utf8_expected_q.size();
    end
  end

endmodule

/* bench/tb_json_string_unescape_utf8.sv */
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;
  import jsu_pkg::*;

  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned RANDOM_BYTES = 300;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] ESC_LETTERS [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62,
                                             8'h66, 8'h6E, 8'h72, 8'h74};

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  int unsigned chk_fails;
  int unsigned chk_pending;
  int unsigned chk_checked;
  int unsigned chk_closed;
  int unsigned chk_flagged;

  int unsigned bytes_sent = 0;
  int unsigned texts_sent = 0;
  int unsigned idle_cycles = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  logic [7:0]  text_q[$];

  // Appends one byte to the text being collected.
  function automatic void add_byte(logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  json_string_unescape_utf8 DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  jsu_stream_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_cnt_o    (chk_fails),
    .pending_o     (chk_pending),
    .checked_o     (chk_checked),
    .closed_o      (chk_closed),
    .flagged_o     (chk_flagged)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 0;
  end

  // The watchdog ends a run in which no transfer happens on either side for
  // far longer than the worst gap and stall of a correct run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", idle_cycles);
        $display("tb_json_string_unescape_utf8: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The receiver stalls a random number of cycles before each result, with
  // calm stretches in which it is always ready.
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Offers one byte after a random gap and returns at the edge that takes it.
  task automatic send_byte(logic [7:0] b, logic eot);
    int gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // Sends the collected text, marking its last byte as the end of text if asked.
  task automatic flush_text(bit end_text);
    foreach (text_q[i]) send_byte(text_q[i], end_text && (i == text_q.size() - 1));
    text_q.delete();
    texts_sent++;
  endtask

  function automatic bit is_hex_char(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic bit is_escape_char(logic [7:0] c);
    foreach (ESC_LETTERS[i]) if (c == ESC_LETTERS[i]) return 1'b1;
    return c == CH_U;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  // A byte that may stand unescaped inside a string.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_hex_char(b));
    return b;
  endfunction

  function automatic logic [15:0] high_unit();
    return 16'hD800 + 16'($urandom_range(0, 16'h03FF));
  endfunction

  function automatic logic [15:0] low_unit();
    return 16'hDC00 + 16'($urandom_range(0, 16'h03FF));
  endfunction

  // A code unit from one of the UTF-8 length classes or the surrogate ranges.
  function automatic logic [15:0] any_unit();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hFFFF));
      3:       return high_unit();
      4:       return low_unit();
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  task automatic add_unit(logic [15:0] v);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(v[i*4 +: 4]));
  endtask

  // A \u escape cut short by a non-hex character after zero to three good digits.
  task automatic add_broken_unit();
    int good;
    good = $urandom_range(0, 3);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    repeat (good) add_byte(hex_char(4'($urandom_range(0, 15))));
    add_byte(bad_hex_char());
  endtask

  // Appends one piece of string content; broken is set when the piece makes
  // the decoder report an error, which ends the string.
  task automatic add_token(output bit broken);
    logic [7:0]  b;
    logic [15:0] v;
    broken = 1'b0;
    case ($urandom_range(0, 21))
      0, 1, 2, 3, 4, 5: add_byte(plain_byte());
      6, 7, 8: begin
        add_byte(CH_BSLASH);
        add_byte(ESC_LETTERS[$urandom_range(0, 7)]);
      end
      9, 10, 11: add_unit(any_unit());
      12, 13: begin
        add_unit(high_unit());
        add_unit(low_unit());
      end
      14: begin
        // High surrogate followed by an escape that does not pair with it.
        add_unit(high_unit());
        do v = any_unit(); while (v >= 16'hDC00 && v <= 16'hDFFF);
        add_unit(v);
      end
      15: begin
        add_unit(high_unit());
        add_byte(CH_BSLASH);
        add_byte(ESC_LETTERS[$urandom_range(0, 7)]);
      end
      16: begin
        add_unit(high_unit());
        add_byte(plain_byte());
      end
      17, 18: add_unit(low_unit());
      19: add_unit(high_unit());
      20: begin
        // A high surrogate pushed out by a second high one, which then pairs
        // with the low surrogate after it.
        add_unit(high_unit());
        add_unit(high_unit());
        add_unit(low_unit());
      end
      default: begin
        broken = 1'b1;
        case ($urandom_range(0, 2))
          0: begin
            do b = 8'($urandom_range(0, 255)); while (is_escape_char(b));
            add_byte(CH_BSLASH);
            add_byte(b);
          end
          1: add_broken_unit();
          default: begin
            add_unit(high_unit());
            add_broken_unit();
          end
        endcase
      end
    endcase
  endtask

  initial begin
    bit         broken;
    int         n_tokens;
    int         ending;
    logic [7:0] b;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed texts: a missing opening quote with the top byte value, the
    // lowest and highest raw bytes followed by an unknown escape, a held high
    // surrogate followed by plain text before the close, a bad hex digit, and
    // a text that ends inside the string.
    text_q = '{8'hFF};
    flush_text(1'b0);
    text_q = '{CH_QUOTE, 8'h00, 8'hFF, CH_BSLASH, 8'h71};
    flush_text(1'b0);
    text_q = '{CH_QUOTE, CH_BSLASH, CH_U, 8'h44, 8'h38, 8'h30, 8'h30, 8'h78, CH_QUOTE};
    flush_text(1'b0);
    text_q = '{CH_QUOTE, CH_BSLASH, CH_U, 8'h67};
    flush_text(1'b0);
    text_q = '{CH_QUOTE, 8'h61};
    flush_text(1'b1);

    // Random part: mostly well-formed strings with random content, some
    // truncated or broken, and a little noise outside any string.
    while (bytes_sent < RANDOM_BYTES + 21) begin
      if ($urandom_range(0, 9) == 0) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
        add_byte(b);
        flush_text($urandom_range(0, 3) == 0);
      end else begin
        add_byte(CH_QUOTE);
        n_tokens = $urandom_range(0, 6);
        broken = 1'b0;
        for (int i = 0; i < n_tokens && !broken; i++) add_token(broken);
        if (broken) begin
          flush_text(1'b0);
        end else begin
          ending = $urandom_range(0, 19);
          if (ending == 0) begin
            flush_text(1'b1);
          end else begin
            add_byte(CH_QUOTE);
            flush_text(ending < 3);
          end
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    do @(negedge clk_i); while (chk_pending != 0);
    repeat (20) @(negedge clk_i);

    $display("sent %0d bytes in %0d texts, including surrogate pairs, held surrogates,",
             bytes_sent, texts_sent);
    $display("broken escapes and early ends; %0d results checked, %0d closes, %0d errors",
             chk_checked, chk_closed, chk_flagged);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("tb_json_string_unescape_utf8: clean");
    end else begin
      $display("%0d mismatches, %0d expected results never arrived", chk_fails, chk_pending);
      $display("tb_json_string_unescape_utf8: errors");
    end
    $finish;
  end

endmodule
